// ===== src/rv32c_pkg.sv =====
// rv32c_pkg: types, constants and opcode codes shared by the rv32i subset core
// depends on nothing; imported by rv32c_exec and rv32i_subset_core_unit
package rv32c_pkg;

   // data memory geometry, word addressed, power-of-two depth
   localparam int DMEM_AW    = 5;
   localparam int DMEM_WORDS = 1 << DMEM_AW;

   // clearing sweep covers both the register file and the data memory
   localparam int CLR_AW = (DMEM_AW > 5) ? DMEM_AW : 5;

   // item modes
   typedef enum logic [1:0] {
      MODE_EXEC        = 2'd0,
      MODE_PRELOAD_REG = 2'd1,
      MODE_PRELOAD_MEM = 2'd2,
      MODE_NONE        = 2'd3
   } mode_type;

   // major opcodes
   localparam logic [6:0] OP_LOAD   = 7'h03;
   localparam logic [6:0] OP_IMM    = 7'h13;
   localparam logic [6:0] OP_STORE  = 7'h23;
   localparam logic [6:0] OP_REG    = 7'h33;
   localparam logic [6:0] OP_BRANCH = 7'h63;
   localparam logic [6:0] OP_JALR   = 7'h67;
   localparam logic [6:0] OP_JAL    = 7'h6F;

   // funct3 and funct7 codes
   localparam logic [2:0] F3_ADD = 3'd0;
   localparam logic [2:0] F3_OR  = 3'd6;
   localparam logic [2:0] F3_AND = 3'd7;
   localparam logic [2:0] F3_BEQ = 3'd0;
   localparam logic [2:0] F3_BNE = 3'd1;
   localparam logic [6:0] F7_BASE = 7'h00;
   localparam logic [6:0] F7_SUB  = 7'h20;

   // outcome of one transaction, from the execute logic to the pipeline
   typedef struct packed {
      logic [31:0]        next_pc;
      logic               recognized;
      logic               reg_written;
      logic [4:0]         reg_number;
      logic [31:0]        reg_value;
      logic               is_load;
      logic               mem_written;
      logic [DMEM_AW-1:0] dm_index;
      logic [4:0]         mem_word_index;
      logic [31:0]        mem_value;
   } exec_result_type;

endpackage

// ===== src/rv32c_ram.sv =====
// rv32c_ram: generic single write port, single registered read port RAM
// depends on nothing; read during write of the same address returns old data
module rv32c_ram #(
   parameter int  WIDTH = 32,
   parameter int  DEPTH = 32,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/rv32c_exec.sv =====
// rv32c_exec: decode and execute of one transaction (alu, branch, jump, address)
// depends on rv32c_pkg
module rv32c_exec
   import rv32c_pkg::*;
(
   input  logic [1:0]      mode,
   input  logic [31:0]     instruction,
   input  logic [4:0]      preload_index,
   input  logic [31:0]     preload_value,
   input  logic [31:0]     pc,
   input  logic [31:0]     op_a,
   input  logic [31:0]     op_b,
   output exec_result_type result
);

   // alu for register-immediate and register-register forms
   function automatic logic [31:0] alu(input logic is_imm, input logic [2:0] f3,
                                       input logic [6:0] f7, input logic [31:0] a,
                                       input logic [31:0] b);
      logic [31:0] r;
      r = 32'd0;
      if (is_imm) begin
         unique case (f3)
            F3_ADD:  r = a + b;
            F3_AND:  r = a & b;
            F3_OR:   r = a | b;
            default: r = 32'd0;
         endcase
      end else begin
         priority if (f3 == F3_ADD && f7 == F7_BASE) r = a + b;
         else if (f3 == F3_ADD && f7 == F7_SUB) r = a - b;
         else if (f3 == F3_AND && f7 == F7_BASE) r = a & b;
         else if (f3 == F3_OR && f7 == F7_BASE) r = a | b;
         else r = 32'd0;
      end
      return r;
   endfunction

   logic [6:0]            opcode;
   logic [4:0]            rd;
   logic [2:0]            funct3;
   logic [6:0]            funct7;
   logic [31:0]           imm_i;
   logic [31:0]           imm_s;
   logic [31:0]           imm_b;
   logic [31:0]           imm_j;
   logic [31:0]           sum_i;
   logic [31:0]           sum_s;
   logic [31:0]           pc_plus4;
   logic                  wr;
   logic [31:0]           wr_value;
   logic [DMEM_AW+4:0]    pidx_ext;
   logic [DMEM_AW+4:0]    idx_ext;

   // field extraction and immediates
   assign opcode   = instruction[6:0];
   assign rd       = instruction[11:7];
   assign funct3   = instruction[14:12];
   assign funct7   = instruction[31:25];
   assign imm_i    = {{20{instruction[31]}}, instruction[31:20]};
   assign imm_s    = {{20{instruction[31]}}, instruction[31:25], instruction[11:7]};
   assign imm_b    = {{19{instruction[31]}}, instruction[31], instruction[7],
                      instruction[30:25], instruction[11:8], 1'b0};
   assign imm_j    = {{11{instruction[31]}}, instruction[31], instruction[19:12],
                      instruction[20], instruction[30:21], 1'b0};
   assign sum_i    = op_a + imm_i;
   assign sum_s    = op_a + imm_s;
   assign pc_plus4 = pc + 32'd4;
   assign pidx_ext = {{DMEM_AW{1'b0}}, preload_index};

   // per-mode and per-opcode behavior
   always_comb begin
      result   = '0;
      result.next_pc = pc;
      wr       = 1'b0;
      wr_value = 32'd0;
      unique case (mode_type'(mode))
         MODE_PRELOAD_REG: begin
            if (preload_index != 5'd0) begin
               result.reg_written = 1'b1;
               result.reg_number  = preload_index;
               result.reg_value   = preload_value;
            end
         end
         MODE_PRELOAD_MEM: begin
            result.mem_written = 1'b1;
            result.dm_index    = pidx_ext[DMEM_AW-1:0];
            result.mem_value   = preload_value;
         end
         MODE_EXEC: begin
            result.next_pc    = pc_plus4;
            result.recognized = 1'b1;
            unique case (opcode)
               OP_LOAD: begin
                  // value arrives from data memory one stage later
                  result.is_load  = 1'b1;
                  result.dm_index = sum_i[DMEM_AW+1:2];
                  wr = 1'b1;
               end
               OP_IMM: begin
                  wr_value = alu(1'b1, funct3, funct7, op_a, imm_i);
                  wr = 1'b1;
               end
               OP_STORE: begin
                  result.mem_written = 1'b1;
                  result.dm_index    = sum_s[DMEM_AW+1:2];
                  result.mem_value   = op_b;
               end
               OP_REG: begin
                  wr_value = alu(1'b0, funct3, funct7, op_a, op_b);
                  wr = 1'b1;
               end
               OP_BRANCH: begin
                  if ((funct3 == F3_BEQ && op_a == op_b) ||
                      (funct3 == F3_BNE && op_a != op_b)) begin
                     result.next_pc = pc + imm_b;
                  end
               end
               OP_JAL: begin
                  wr_value = pc_plus4;
                  wr = 1'b1;
                  result.next_pc = pc + imm_j;
               end
               OP_JALR: begin
                  wr_value = pc_plus4;
                  wr = 1'b1;
                  result.next_pc = {sum_i[31:1], 1'b0};
               end
               default: begin
                  result.recognized = 1'b0;
               end
            endcase
            // x0 is never written
            if (wr && rd != 5'd0) begin
               result.reg_written = 1'b1;
               result.reg_number  = rd;
               result.reg_value   = wr_value;
            end
         end
         MODE_NONE: begin
         end
         default: begin
         end
      endcase
      // reported word index, low five bits
      idx_ext = {5'd0, result.dm_index};
      if (result.mem_written) begin
         result.mem_word_index = idx_ext[4:0];
      end
   end

endmodule

// ===== src/rv32i_subset_core_unit.sv =====
// rv32i_subset_core_unit: top level of the rv32i subset core, three-register pipeline
// depends on rv32c_pkg, rv32c_exec and rv32c_ram
//
// usage:
//   req channel carries one transaction: execute an instruction fetched at the
//   current pc, preload a register, or preload a data memory word
//   rsp channel returns one result per transaction, in order: next pc and any
//   register or data memory write
// path: an accepted transaction passes operand read, execute, write back and the
//   output register in turn before it appears on rsp
// throughput: one transaction per cycle while req_stall is low; forwarding from
//   the write-back stage and a per-operand patch register cover every register
//   dependency, including a load followed directly by a user of its value
// reset: pc and pipeline valids clear, then a sweep of every address writes zero
//   into the register file and the data memory, one word per cycle; req_stall
//   stays high meanwhile
// rsp_stall: the output register holds its payload; the stages behind it keep
//   filling and req_stall rises only once every stage holds a transaction
module rv32i_subset_core_unit
   import rv32c_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_instruction,
   input  logic [4:0]  req_preload_index,
   input  logic [31:0] req_preload_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_next_pc,
   output logic        rsp_recognized,
   output logic        rsp_reg_written,
   output logic [4:0]  rsp_reg_number,
   output logic [31:0] rsp_reg_value,
   output logic        rsp_mem_written,
   output logic [4:0]  rsp_mem_word_index,
   output logic [31:0] rsp_mem_value
);

   // clearing sweep
   logic              clear_busy_ff, clear_busy_in;
   logic [CLR_AW-1:0] clr_cnt_ff, clr_cnt_in;

   // program counter
   logic [31:0] pc_ff, pc_in;

   // stage 1: accepted transaction with operands read from the register file
   logic        s1_valid_ff, s1_valid_in;
   logic [1:0]  s1_mode_ff;
   logic [31:0] s1_instruction_ff;
   logic [4:0]  s1_preload_index_ff;
   logic [31:0] s1_preload_value_ff;
   logic        pa_valid_ff, pa_valid_in;
   logic [31:0] pa_data_ff, pa_data_in;
   logic        pb_valid_ff, pb_valid_in;
   logic [31:0] pb_data_ff, pb_data_in;

   // stage 2: executed transaction, waiting for load data and write back
   logic            s2_valid_ff, s2_valid_in;
   exec_result_type s2_ff;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_next_pc_ff;
   logic        rsp_recognized_ff;
   logic        rsp_reg_written_ff;
   logic [4:0]  rsp_reg_number_ff;
   logic [31:0] rsp_reg_value_ff;
   logic        rsp_mem_written_ff;
   logic [4:0]  rsp_mem_word_index_ff;
   logic [31:0] rsp_mem_value_ff;

   // pipeline control
   logic en3, en2, en1;
   logic mv23, mv12, accept;

   // datapath
   logic [4:0]         rs1, rs2;
   logic [4:0]         req_rs1, req_rs2;
   logic [31:0]        rf_a_rdata, rf_b_rdata;
   logic [31:0]        op_a, op_b;
   logic [31:0]        s2_value;
   logic [31:0]        dm_rdata;
   exec_result_type    ex;
   logic               commit;
   logic               rf_we;
   logic [4:0]         rf_waddr;
   logic [31:0]        rf_wdata;
   logic               dm_we;
   logic               dm_re;
   logic [DMEM_AW-1:0] dm_waddr;
   logic [31:0]        dm_wdata;

   // stage enables, each stage moves when the one ahead has room
   assign en3       = !rsp_valid_ff || !rsp_stall;
   assign mv23      = s2_valid_ff && en3;
   assign en2       = !s2_valid_ff || en3;
   assign mv12      = s1_valid_ff && en2;
   assign en1       = !s1_valid_ff || en2;
   assign req_stall = clear_busy_ff || !en1;
   assign accept    = req_valid && !req_stall;

   // clearing sweep after reset
   always_comb begin
      clear_busy_in = clear_busy_ff;
      clr_cnt_in    = clr_cnt_ff;
      if (clear_busy_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == {CLR_AW{1'b1}}) begin
            clear_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clr_cnt_ff    <= '0;
      end else begin
         clear_busy_ff <= clear_busy_in;
         clr_cnt_ff    <= clr_cnt_in;
      end
   end

   // register file, one copy per read port
   assign req_rs1  = req_instruction[19:15];
   assign req_rs2  = req_instruction[24:20];
   assign commit   = mv23 && s2_ff.reg_written;
   assign s2_value = s2_ff.is_load ? dm_rdata : s2_ff.reg_value;
   assign rf_we    = clear_busy_ff || commit;
   assign rf_waddr = clear_busy_ff ? clr_cnt_ff[4:0] : s2_ff.reg_number;
   assign rf_wdata = clear_busy_ff ? 32'd0 : s2_value;

   rv32c_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (rf_waddr),
      .wr_data (rf_wdata),
      .rd_en   (accept),
      .rd_addr (req_rs1),
      .rd_data (rf_a_rdata)
   );

   rv32c_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (rf_waddr),
      .wr_data (rf_wdata),
      .rd_en   (accept),
      .rd_addr (req_rs2),
      .rd_data (rf_b_rdata)
   );

   // stage 1 capture
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (mv12) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_mode_ff          <= req_mode;
         s1_instruction_ff   <= req_instruction;
         s1_preload_index_ff <= req_preload_index;
         s1_preload_value_ff <= req_preload_value;
      end
   end

   // operand patch: write backs the register file read did not see
   assign rs1 = s1_instruction_ff[19:15];
   assign rs2 = s1_instruction_ff[24:20];

   always_comb begin
      pa_valid_in = pa_valid_ff;
      pa_data_in  = pa_data_ff;
      pb_valid_in = pb_valid_ff;
      pb_data_in  = pb_data_ff;
      if (accept) begin
         pa_valid_in = commit && (s2_ff.reg_number == req_rs1);
         pb_valid_in = commit && (s2_ff.reg_number == req_rs2);
         pa_data_in  = s2_value;
         pb_data_in  = s2_value;
      end else if (s1_valid_ff && commit) begin
         if (s2_ff.reg_number == rs1) begin
            pa_valid_in = 1'b1;
            pa_data_in  = s2_value;
         end
         if (s2_ff.reg_number == rs2) begin
            pb_valid_in = 1'b1;
            pb_data_in  = s2_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pa_valid_ff <= 1'b0;
         pb_valid_ff <= 1'b0;
      end else begin
         pa_valid_ff <= pa_valid_in;
         pb_valid_ff <= pb_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pa_data_ff <= pa_data_in;
      pb_data_ff <= pb_data_in;
   end

   // operand select: pending write back first, then patch, then register file
   always_comb begin
      priority if (s2_valid_ff && s2_ff.reg_written && s2_ff.reg_number == rs1) begin
         op_a = s2_value;
      end else if (pa_valid_ff) begin
         op_a = pa_data_ff;
      end else begin
         op_a = rf_a_rdata;
      end
      priority if (s2_valid_ff && s2_ff.reg_written && s2_ff.reg_number == rs2) begin
         op_b = s2_value;
      end else if (pb_valid_ff) begin
         op_b = pb_data_ff;
      end else begin
         op_b = rf_b_rdata;
      end
   end

   // execute
   rv32c_exec u_exec (
      .mode          (s1_mode_ff),
      .instruction   (s1_instruction_ff),
      .preload_index (s1_preload_index_ff),
      .preload_value (s1_preload_value_ff),
      .pc            (pc_ff),
      .op_a          (op_a),
      .op_b          (op_b),
      .result        (ex)
   );

   // pc advances as a transaction leaves stage 1
   assign pc_in = mv12 ? ex.next_pc : pc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= 32'd0;
      end else begin
         pc_ff <= pc_in;
      end
   end

   // data memory: stores commit and loads read as a transaction leaves stage 1
   assign dm_we    = clear_busy_ff || (mv12 && ex.mem_written);
   assign dm_waddr = clear_busy_ff ? clr_cnt_ff[DMEM_AW-1:0] : ex.dm_index;
   assign dm_wdata = clear_busy_ff ? 32'd0 : ex.mem_value;
   assign dm_re    = mv12 && ex.is_load;

   rv32c_ram #(.WIDTH(32), .DEPTH(DMEM_WORDS)) u_dmem (
      .clock   (clock),
      .wr_en   (dm_we),
      .wr_addr (dm_waddr),
      .wr_data (dm_wdata),
      .rd_en   (dm_re),
      .rd_addr (ex.dm_index),
      .rd_data (dm_rdata)
   );

   // stage 2
   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (mv12) begin
         s2_valid_in = 1'b1;
      end else if (mv23) begin
         s2_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mv12) begin
         s2_ff <= ex;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (mv23) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mv23) begin
         rsp_next_pc_ff        <= s2_ff.next_pc;
         rsp_recognized_ff     <= s2_ff.recognized;
         rsp_reg_written_ff    <= s2_ff.reg_written;
         rsp_reg_number_ff     <= s2_ff.reg_number;
         rsp_reg_value_ff      <= s2_ff.reg_written ? s2_value : 32'd0;
         rsp_mem_written_ff    <= s2_ff.mem_written;
         rsp_mem_word_index_ff <= s2_ff.mem_word_index;
         rsp_mem_value_ff      <= s2_ff.mem_value;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_next_pc        = rsp_next_pc_ff;
   assign rsp_recognized     = rsp_recognized_ff;
   assign rsp_reg_written    = rsp_reg_written_ff;
   assign rsp_reg_number     = rsp_reg_number_ff;
   assign rsp_reg_value      = rsp_reg_value_ff;
   assign rsp_mem_written    = rsp_mem_written_ff;
   assign rsp_mem_word_index = rsp_mem_word_index_ff;
   assign rsp_mem_value      = rsp_mem_value_ff;

   // no transaction enters while the sweep runs
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_busy_ff |-> (req_stall && !s1_valid_ff && !s2_valid_ff))
      else $error("transaction in flight during clearing sweep");

   // write back never targets x0 outside the sweep
   a_no_x0_write: assert property (@(posedge clock) disable iff (reset)
      (rf_we && !clear_busy_ff) |-> (rf_waddr != 5'd0))
      else $error("register file write to x0");

   // pc only moves when a transaction leaves stage 1
   a_pc_hold: assert property (@(posedge clock) disable iff (reset)
      !mv12 |=> $stable(pc_ff))
      else $error("pc changed without a retiring transaction");

   // data memory port serves a store or a load, never both
   a_dm_port: assert property (@(posedge clock) disable iff (reset)
      !(dm_re && (dm_we || clear_busy_ff)))
      else $error("data memory read and write in the same cycle");

   // a load result never skips the stage that collects its data
   a_load_stage: assert property (@(posedge clock) disable iff (reset)
      dm_re |=> (s2_valid_ff && s2_ff.is_load))
      else $error("load data not matched to stage 2");

endmodule
